@@ rtl/mefqd_pkg.sv @@
// ----------------------------------------------------------------------------
// mefqd_pkg
// Shared types and codes for the multi-endpoint frame queue with ordered drain.
// ----------------------------------------------------------------------------
package mefqd_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 16;
    localparam int TOKEN_W  = 32;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 2;
    localparam int STAMP_W  = 32;
    localparam int MAX_OUT  = 64;
    localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = 16'd256;

    typedef enum logic [OP_W-1:0] {
        OP_ATTACH  = 2'd0,
        OP_DETACH  = 2'd1,
        OP_ENQUEUE = 2'd2,
        OP_DRAIN   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_ATTACHED = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_TOO_BIG  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_LOAD
    } t_state;

endpackage

@@ rtl/multi_endpoint_frame_queue_drain.sv @@
// ----------------------------------------------------------------------------
// multi_endpoint_frame_queue_drain
// Endpoint table with one descriptor ring per position and a drain that
// empties the rings in position order up to the drain limit, stamping each frame.
//
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_op, i_client_id, i_frame_size,
//                                          i_frame_token, i_drain_limit
// output    out        o_valid / i_stall  o_status, o_position, o_frame_valid,
//                                          o_out_token, o_out_size, o_stamp,
//                                          o_drained_count, o_last
// config    in         i_cfg_wr_en        i_cfg_wr_data (max frame bytes)
//
// attach, detach and enqueue give one result each, one request per cycle while
// idle and the output is free. a drain reads each frame in S_DRAIN and loads it in
// S_LOAD before the next read: the single read port of the descriptor RAM and its
// registered read set this. an empty drain gives a single result with no frame.
// synchronous reset, no clearing pass; ring contents are undefined until written.
// a stall on the output holds the result register and stops new requests.
// ----------------------------------------------------------------------------
module multi_endpoint_frame_queue_drain
    import mefqd_pkg::*;
#(
    parameter int POSITIONS  = 4,
    parameter int RING_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_client_id,
    input  logic [SIZE_W-1:0]   i_frame_size,
    input  logic [TOKEN_W-1:0]  i_frame_token,
    input  logic [CNT_W-1:0]    i_drain_limit,
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]    o_position,
    output logic                o_frame_valid,
    output logic [TOKEN_W-1:0]  o_out_token,
    output logic [SIZE_W-1:0]   o_out_size,
    output logic [STAMP_W-1:0]  o_stamp,
    output logic [CNT_W-1:0]    o_drained_count,
    output logic                o_last
);

    localparam int PW     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int PXW    = (PW < POS_W) ? POS_W : PW;
    localparam int PTW    = $clog2(2 * RING_DEPTH);
    localparam int SW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DEPTH  = POSITIONS * RING_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = TOKEN_W + SIZE_W;
    localparam logic [PTW-1:0] PTR_LAST = PTW'(2 * RING_DEPTH - 1);
    localparam logic [PTW-1:0] RD_PTR   = PTW'(RING_DEPTH);

    // endpoint table
    logic [ID_W-1:0]     r_client [POSITIONS];
    logic [POSITIONS-1:0] r_used;
    logic [PTW-1:0]      r_tail [POSITIONS];
    logic [PTW-1:0]      r_head [POSITIONS];
    logic [PTW-1:0]      r_rel  [POSITIONS];

    logic [SIZE_W-1:0]   r_max_bytes;
    logic [STAMP_W-1:0]  r_drain_cnt;
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_limit;
    logic [PW-1:0]       r_pend_pos;
    logic                r_pend_last;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_pos;
    logic                r_fvalid;
    logic [TOKEN_W-1:0]  r_token;
    logic [SIZE_W-1:0]   r_size;
    logic [STAMP_W-1:0]  r_stamp;
    logic [CNT_W-1:0]    r_dcount;
    logic                r_last;

    // lookup
    logic [POSITIONS-1:0] hit_vec, nonempty;
    logic                 hit_any, free_any;
    logic [PW-1:0]        hit_idx, free_idx, drn_idx, sel_idx;
    logic [PTW-1:0]       sel_tail, sel_head, sel_rel, sel_ptr, ptr_inc;
    logic [PTW:0]         occ;
    logic                 ring_full;
    logic [SW-1:0]        slot;
    logic [AW-1:0]        ram_addr;
    logic [DW-1:0]        ram_rd_data;
    logic [POSITIONS-1:0] mask_after;
    logic [CNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]     lim_sat;
    logic                 drain_done;

    // control
    logic                 out_free, accept, out_take;
    logic                 load_single, load_empty, load_frame, issue, finish;
    logic                 ram_wr;
    logic [STATUS_W-1:0]  single_status;
    logic [PW-1:0]        single_pos;
    logic [PXW-1:0]       pos_ext_single, pos_ext_frame;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        drn_idx  = '0;
        for (int g = POSITIONS - 1; g >= 0; g--) begin
            hit_vec[g]  = r_used[g] && (r_client[g] == i_client_id);
            nonempty[g] = r_used[g] && (r_head[g] != r_tail[g]);
            if (hit_vec[g]) begin
                hit_idx = PW'(g);
            end
            if (!r_used[g]) begin
                free_idx = PW'(g);
            end
            if (nonempty[g]) begin
                drn_idx = PW'(g);
            end
        end
        hit_any  = |hit_vec;
        free_any = ~&r_used;
    end

    // one pointer read per cycle: client position when idle, drain position otherwise
    assign sel_idx  = (r_state == S_IDLE) ? hit_idx : drn_idx;
    assign sel_tail = r_tail[sel_idx];
    assign sel_head = r_head[sel_idx];
    assign sel_rel  = r_rel[sel_idx];

    assign occ = (sel_tail >= sel_rel) ? ({1'b0, sel_tail} - {1'b0, sel_rel})
                                       : ({1'b0, sel_tail} + (PTW+1)'(2 * RING_DEPTH)
                                          - {1'b0, sel_rel});
    assign ring_full = occ >= (PTW+1)'(RING_DEPTH);

    assign sel_ptr  = (r_state == S_IDLE) ? sel_tail : sel_head;
    assign ptr_inc  = (sel_ptr == PTR_LAST) ? '0 : sel_ptr + PTW'(1);
    assign slot     = (sel_ptr >= RD_PTR) ? SW'(sel_ptr - RD_PTR) : SW'(sel_ptr);
    assign ram_addr = AW'(AW'(sel_idx) * RING_DEPTH) + AW'(slot);

    always_comb begin
        mask_after = nonempty;
        if (ptr_inc == sel_tail) begin
            mask_after[drn_idx] = 1'b0;
        end
    end

    assign count_inc  = r_count + CNT_W'(1);
    assign lim_sat    = (i_drain_limit > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : i_drain_limit;
    assign drain_done = (nonempty == '0) || (r_count == r_limit);

    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_DRAIN)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_done) begin
                    if ((r_count != '0) || out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = r_pend_last ? S_IDLE : S_DRAIN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        load_single = 1'b0;
        load_empty  = 1'b0;
        load_frame  = 1'b0;
        issue       = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                load_single = accept && (i_op != OP_DRAIN);
            end
            S_DRAIN: begin
                if (drain_done) begin
                    if (r_count != '0) begin
                        finish = 1'b1;
                    end else if (out_free) begin
                        load_empty = 1'b1;
                        finish     = 1'b1;
                    end
                end else if (out_free) begin
                    issue = 1'b1;
                end
            end
            S_LOAD: begin
                load_frame = 1'b1;
                finish     = r_pend_last;
            end
            default: ;
        endcase
    end

    // single-result operations
    always_comb begin
        single_status = ST_DONE;
        single_pos    = '0;
        ram_wr        = 1'b0;
        unique case (t_op'(i_op))
            OP_ATTACH: begin
                if (hit_any) begin
                    single_status = ST_ATTACHED;
                    single_pos    = hit_idx;
                end else if (free_any) begin
                    single_pos    = free_idx;
                end else begin
                    single_status = ST_NO_FREE;
                end
            end
            OP_DETACH: begin
                if (hit_any) begin
                    single_pos    = hit_idx;
                end else begin
                    single_status = ST_UNKNOWN;
                end
            end
            OP_ENQUEUE: begin
                if (!hit_any) begin
                    single_status = ST_UNKNOWN;
                end else if (i_frame_size > r_max_bytes) begin
                    single_status = ST_TOO_BIG;
                    single_pos    = hit_idx;
                end else if (ring_full) begin
                    single_status = ST_FULL;
                    single_pos    = hit_idx;
                end else begin
                    single_pos    = hit_idx;
                    ram_wr        = load_single;
                end
            end
            default: ;
        endcase
    end

    assign pos_ext_single = PXW'(single_pos);
    assign pos_ext_frame  = PXW'(r_pend_pos);

    mefqd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (ram_addr),
        .i_wr_data ({i_frame_token, i_frame_size}),
        .i_rd_en   (issue),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    // endpoint table and drain bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_max_bytes <= MAX_BYTES_RESET;
            r_drain_cnt <= '0;
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= '0;
            for (int g = 0; g < POSITIONS; g++) begin
                r_client[g] <= '0;
                r_tail[g]   <= '0;
                r_head[g]   <= '0;
                r_rel[g]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_max_bytes <= i_cfg_wr_data;
            end
            if (load_single) begin
                if ((i_op == OP_ATTACH) && !hit_any && free_any) begin
                    r_used[free_idx]   <= 1'b1;
                    r_client[free_idx] <= i_client_id;
                    r_tail[free_idx]   <= '0;
                    r_head[free_idx]   <= '0;
                    r_rel[free_idx]    <= '0;
                end
                if ((i_op == OP_DETACH) && hit_any) begin
                    r_used[hit_idx] <= 1'b0;
                end
            end
            if (ram_wr) begin
                r_tail[hit_idx] <= ptr_inc;
            end
            if (accept && (i_op == OP_DRAIN)) begin
                r_count <= '0;
                r_limit <= lim_sat;
                for (int g = 0; g < POSITIONS; g++) begin
                    r_rel[g] <= r_head[g];
                end
            end
            if (issue) begin
                r_head[drn_idx] <= ptr_inc;
                r_count         <= count_inc;
            end
            if (finish) begin
                r_drain_cnt <= r_drain_cnt + STAMP_W'(1);
            end
        end
    end

    // pending frame, sampled with the read request
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_pos  <= drn_idx;
            r_pend_last <= (count_inc == r_limit) || (mask_after == '0);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_single || load_empty || load_frame) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_single || load_empty) begin
            r_status <= load_single ? single_status : ST_DONE;
            r_pos    <= load_single ? pos_ext_single[POS_W-1:0] : '0;
            r_fvalid <= 1'b0;
            r_token  <= '0;
            r_size   <= '0;
            r_stamp  <= '0;
            r_dcount <= '0;
            r_last   <= 1'b1;
        end else if (load_frame) begin
            r_status <= ST_DONE;
            r_pos    <= pos_ext_frame[POS_W-1:0];
            r_fvalid <= 1'b1;
            r_token  <= ram_rd_data[DW-1:SIZE_W];
            r_size   <= ram_rd_data[SIZE_W-1:0];
            r_stamp  <= r_drain_cnt;
            r_dcount <= r_count;
            r_last   <= r_pend_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_position      = r_pos;
    assign o_frame_valid   = r_fvalid;
    assign o_out_token     = r_token;
    assign o_out_size      = r_size;
    assign o_stamp         = r_stamp;
    assign o_drained_count = r_dcount;
    assign o_last          = r_last;

`ifndef SYNTHESIS
    // the frame load relies on the result register having been freed at issue
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_out_valid)
        else $error("frame load over a held result");

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count <= r_limit))
        else $error("drain count beyond limit");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (r_state == S_IDLE))
        else $error("request taken during a drain");

    a_frame_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fvalid) |-> ((r_dcount != '0) && (r_status == ST_DONE)))
        else $error("drained frame without count");
`endif

endmodule

@@ rtl/mefqd_ram.sv @@
// ----------------------------------------------------------------------------
// mefqd_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module mefqd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
